>>> design/tmb_pkg.sv
// ----------------------------------------------------------------------------
// tmb_pkg
// Shared types and constants for the temporal median background block.
// ----------------------------------------------------------------------------
`default_nettype none

package tmb_pkg;

   localparam int unsigned WINDOW_DEFAULT = 8;
   localparam int unsigned PIXELS_DEFAULT = 65536;

   localparam int unsigned CHANNELS = 3;
   localparam int unsigned SAMPLE_W = 8;
   localparam int unsigned INDEX_W  = 16;

   localparam int unsigned CH_BLUE  = 0;
   localparam int unsigned CH_GREEN = 1;
   localparam int unsigned CH_RED   = 2;

   typedef logic [SAMPLE_W-1:0] sample_type;
   typedef logic [INDEX_W-1:0]  index_type;

   // BT.601 gray weights in Q14; weighted sum of three 8-bit values fits 22 bits
   localparam int unsigned WEIGHT_W   = 14;
   localparam int unsigned GRAY_W     = 22;
   localparam int unsigned GRAY_SHIFT = 14;

   typedef logic [WEIGHT_W-1:0] weight_type;
   typedef logic [GRAY_W-1:0]   gray_type;

   localparam weight_type GRAY_WEIGHT [CHANNELS] = '{14'd1868, 14'd9617, 14'd4899};
   localparam gray_type   GRAY_ROUND            = 22'd8192;

   localparam sample_type THRESHOLD_RESET = 8'd50;

endpackage

`default_nettype wire

>>> design/tmb_req_if.sv
// ----------------------------------------------------------------------------
// tmb_req_if
// Pixel word channel: raster index, color samples and end-of-frame flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface tmb_req_if
   import tmb_pkg::*;
();
   logic       valid;
   logic       ready;
   index_type  pixel_index;
   sample_type blue;
   sample_type green;
   sample_type red;
   logic       frame_end;

   modport source (output valid, pixel_index, blue, green, red, frame_end, input ready);
   modport sink   (input valid, pixel_index, blue, green, red, frame_end, output ready);
endinterface

`default_nettype wire

>>> design/tmb_rsp_if.sv
// ----------------------------------------------------------------------------
// tmb_rsp_if
// Result word channel: per-channel background and foreground flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface tmb_rsp_if
   import tmb_pkg::*;
();
   logic       valid;
   logic       ready;
   sample_type background_blue;
   sample_type background_green;
   sample_type background_red;
   logic       foreground;

   modport source (output valid, background_blue, background_green, background_red,
                   foreground, input ready);
   modport sink   (input valid, background_blue, background_green, background_red,
                   foreground, output ready);
endinterface

`default_nettype wire

>>> design/tmb_csr_if.sv
// ----------------------------------------------------------------------------
// tmb_csr_if
// Register write channel carrying the foreground threshold.
// ----------------------------------------------------------------------------
`default_nettype none

interface tmb_csr_if
   import tmb_pkg::*;
();
   logic       valid;
   logic       ready;
   sample_type data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

>>> design/temporal_median_background_top.sv
// An accepted pixel word passes index reduction (two-step unless PIXELS is a power
// of two or at least 65536), the memory read, the write-back with the registered
// median, the registered gray products and the result word, registered once the
// output is free. One pixel is in flight at a time around its memory word's update.
// Reset clears slot, frame count, handshake state and sets the threshold to 50;
// sample memory is undefined until written, with no clearing pass.
// ----------------------------------------------------------------------------
// temporal_median_background_top
// Temporal median background estimate and foreground flag per color pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module temporal_median_background_top
   import tmb_pkg::*;
#(
   parameter int unsigned WINDOW = WINDOW_DEFAULT,
   parameter int unsigned PIXELS = PIXELS_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,
   tmb_req_if.sink   req_bus,
   tmb_rsp_if.source rsp_bus,
   tmb_csr_if.sink   csr_bus
);

   localparam int unsigned SW     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int unsigned CW     = $clog2(WINDOW + 1);
   localparam int unsigned DW     = SW + 2;
   localparam int unsigned AW     = (PIXELS > 1) ? $clog2(PIXELS) : 1;
   localparam int unsigned WORD_W = WINDOW * CHANNELS * SAMPLE_W;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_REDUCE = 3'd1;
   localparam logic [2:0] ST_READ   = 3'd2;
   localparam logic [2:0] ST_RANK   = 3'd3;
   localparam logic [2:0] ST_GRAY   = 3'd4;

   logic [2:0]    state_ff, state_in;
   logic [SW-1:0] slot_ff, slot_in;
   logic [CW-1:0] frames_ff, frames_in;
   sample_type    thr_ff, thr_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic [CHANNELS*SAMPLE_W-1:0] sample_ff;
   logic                         frame_end_ff;
   logic [AW-1:0]                addr_ff;
   gray_type                     prod_ff [CHANNELS];
   gray_type                     prod_in [CHANNELS];
   sample_type                   out_blue_ff, out_green_ff, out_red_ff;
   logic                         out_fg_ff;

   logic                         accept;
   logic                         red_done;
   logic [AW-1:0]                red_addr;
   logic                         mem_rd_en;
   logic [WORD_W-1:0]            mem_rd_data;
   logic                         mem_wr_en;
   logic [WORD_W-1:0]            merged;
   logic [WINDOW-1:0]            valid_mask;
   logic [CW:0]                  kcount;
   logic [CW-1:0]                mid;
   logic [CHANNELS*SAMPLE_W-1:0] background;
   logic                         out_load;
   gray_type                     gray_sum;
   logic                         fg;

   assign accept        = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign csr_bus.ready = 1'b1;

   tmb_index_reduce #(
      .PIXELS (PIXELS),
      .AW     (AW)
   ) u_reduce (
      .clock       (clock),
      .reset       (reset),
      .start       (accept),
      .pixel_index (req_bus.pixel_index),
      .done        (red_done),
      .addr        (red_addr)
   );

   assign mem_rd_en = (state_ff == ST_REDUCE) && red_done;
   assign mem_wr_en = (state_ff == ST_READ);

   tmb_sample_mem #(
      .DEPTH  (PIXELS),
      .AW     (AW),
      .WORD_W (WORD_W)
   ) u_mem (
      .clock   (clock),
      .rd_en   (mem_rd_en),
      .rd_addr (red_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (addr_ff),
      .wr_data (merged)
   );

   // valid slots: write slot and the k-1 before it, cyclically
   always_comb begin : slot_select
      logic [DW-1:0] slot_gap;
      kcount = (CW + 1)'(frames_ff) + 1'b1;
      if (kcount > (CW + 1)'(WINDOW)) begin
         kcount = (CW + 1)'(WINDOW);
      end
      mid = kcount[CW:1];
      for (int s = 0; s < WINDOW; s++) begin
         slot_gap = DW'(slot_ff) + DW'(WINDOW) - DW'(s);
         if (slot_gap >= DW'(WINDOW)) begin
            slot_gap = slot_gap - DW'(WINDOW);
         end
         valid_mask[s] = (8'(slot_gap) < 8'(kcount));
      end
   end

   // overwrite the current slot with this frame's samples
   always_comb begin
      for (int s = 0; s < WINDOW; s++) begin
         for (int ch = 0; ch < CHANNELS; ch++) begin
            if (SW'(s) == slot_ff) begin
               merged[(s*CHANNELS + ch)*SAMPLE_W +: SAMPLE_W] =
                  sample_ff[ch*SAMPLE_W +: SAMPLE_W];
            end else begin
               merged[(s*CHANNELS + ch)*SAMPLE_W +: SAMPLE_W] =
                  mem_rd_data[(s*CHANNELS + ch)*SAMPLE_W +: SAMPLE_W];
            end
         end
      end
   end

   tmb_median #(
      .WINDOW (WINDOW),
      .CW     (CW),
      .WORD_W (WORD_W)
   ) u_median (
      .clock      (clock),
      .load       (mem_wr_en),
      .word       (merged),
      .valid_mask (valid_mask),
      .mid        (mid),
      .background (background)
   );

   always_comb begin : weigh
      sample_type s;
      sample_type b;
      sample_type ad;
      for (int ch = 0; ch < CHANNELS; ch++) begin
         s  = sample_ff[ch*SAMPLE_W +: SAMPLE_W];
         b  = background[ch*SAMPLE_W +: SAMPLE_W];
         ad = (s > b) ? (s - b) : (b - s);
         prod_in[ch] = GRAY_W'(ad) * GRAY_W'(GRAY_WEIGHT[ch]);
      end
   end

   assign gray_sum = prod_ff[CH_BLUE] + prod_ff[CH_GREEN] + prod_ff[CH_RED] + GRAY_ROUND;
   assign fg       = (gray_sum[GRAY_W-1:GRAY_SHIFT] > thr_ff);
   assign out_load = (state_ff == ST_GRAY) && (!rsp_valid_ff || rsp_bus.ready);

   always_comb begin
      state_in     = state_ff;
      slot_in      = slot_ff;
      frames_in    = frames_ff;
      thr_in       = thr_ff;
      rsp_valid_in = rsp_valid_ff;
      if (csr_bus.valid) begin
         thr_in = csr_bus.data;
      end
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            if (red_done) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_RANK;
            // on a frame's last pixel, advance slot and frame count once the write-back is issued
            if (frame_end_ff) begin
               slot_in = (slot_ff == SW'(WINDOW - 1)) ? '0 : slot_ff + 1'b1;
               if (frames_ff < CW'(WINDOW)) begin
                  frames_in = frames_ff + 1'b1;
               end
            end
         end
         ST_RANK: begin
            state_in = ST_GRAY;
         end
         ST_GRAY: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         slot_ff      <= '0;
         frames_ff    <= '0;
         thr_ff       <= THRESHOLD_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         frames_ff    <= frames_in;
         thr_ff       <= thr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         sample_ff    <= {req_bus.red, req_bus.green, req_bus.blue};
         frame_end_ff <= req_bus.frame_end;
      end
      if (mem_rd_en) begin
         addr_ff <= red_addr;
      end
      if (state_ff == ST_RANK) begin
         for (int ch = 0; ch < CHANNELS; ch++) begin
            prod_ff[ch] <= prod_in[ch];
         end
      end
      if (out_load) begin
         out_blue_ff  <= background[CH_BLUE*SAMPLE_W +: SAMPLE_W];
         out_green_ff <= background[CH_GREEN*SAMPLE_W +: SAMPLE_W];
         out_red_ff   <= background[CH_RED*SAMPLE_W +: SAMPLE_W];
         out_fg_ff    <= fg;
      end
   end

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.background_blue  = out_blue_ff;
   assign rsp_bus.background_green = out_green_ff;
   assign rsp_bus.background_red   = out_red_ff;
   assign rsp_bus.foreground       = out_fg_ff;

   a_wb_follows_read: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> $past(mem_rd_en))
      else $error("write-back without a preceding read");

   a_wb_same_entry: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> (addr_ff == $past(red_addr)))
      else $error("write-back address differs from read address");

   a_frames_bound: assert property (@(posedge clock) disable iff (reset)
      frames_ff <= CW'(WINDOW))
      else $error("frame count beyond window");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_bus.ready)
      else $error("second pixel taken while one is in flight");

endmodule

`default_nettype wire

>>> design/tmb_index_reduce.sv
// ----------------------------------------------------------------------------
// tmb_index_reduce
// Reduces the raster index modulo PIXELS into a memory address. Power-of-two
// or large frames register the low index bits; others register a reciprocal
// multiply for the quotient, then multiply back and subtract.
// ----------------------------------------------------------------------------
`default_nettype none

module tmb_index_reduce
   import tmb_pkg::*;
#(
   parameter int unsigned PIXELS = PIXELS_DEFAULT,
   parameter int unsigned AW     = 16
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire index_type     pixel_index,
   output logic               done,
   output logic [AW-1:0]      addr
);

   localparam bit FAST = (PIXELS >= (1 << INDEX_W)) || ((PIXELS & (PIXELS - 1)) == 0);

   generate
      if (FAST) begin : g_fast
         logic          done_ff;
         logic [AW-1:0] addr_ff;
         logic [31:0]   wide;

         assign wide = 32'(pixel_index);

         always_ff @(posedge clock) begin
            if (reset) begin
               done_ff <= 1'b0;
            end else begin
               done_ff <= start;
            end
         end

         // a single-entry frame maps every index to address zero
         always_ff @(posedge clock) begin
            if (start) begin
               addr_ff <= (PIXELS > 1) ? wide[AW-1:0] : '0;
            end
         end

         assign done = done_ff;
         assign addr = addr_ff;
      end else begin : g_recip
         // (x * RECIP) >> SHIFT equals floor(x / PIXELS) for every 16-bit x
         localparam int unsigned     SHIFT = INDEX_W + $clog2(PIXELS);
         localparam longint unsigned RECIP =
            ((64'd1 << SHIFT) + 64'(PIXELS) - 64'd1) / 64'(PIXELS);
         localparam int unsigned     PW    = 2 * INDEX_W + 1;

         logic          step_ff;
         logic          done_ff;
         index_type     index_ff;
         logic [PW-1:0] prod_ff;
         index_type     quot;
         logic [31:0]   back;
         logic [AW-1:0] rem_ff;

         assign quot = INDEX_W'(prod_ff >> SHIFT);
         assign back = 32'(index_ff) - 32'(quot) * 32'(PIXELS);

         always_ff @(posedge clock) begin
            if (reset) begin
               step_ff <= 1'b0;
               done_ff <= 1'b0;
            end else begin
               step_ff <= start;
               done_ff <= step_ff;
            end
         end

         always_ff @(posedge clock) begin
            if (start) begin
               index_ff <= pixel_index;
               prod_ff  <= PW'(pixel_index) * PW'(RECIP);
            end
            if (step_ff) begin
               rem_ff <= back[AW-1:0];
            end
         end

         assign done = done_ff;
         assign addr = rem_ff;
      end
   endgenerate

endmodule

`default_nettype wire

>>> design/tmb_sample_mem.sv
// ----------------------------------------------------------------------------
// tmb_sample_mem
// Sample store: one word per pixel holding every slot and channel.
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tmb_sample_mem #(
   parameter int unsigned DEPTH  = 65536,
   parameter int unsigned AW     = 16,
   parameter int unsigned WORD_W = 192
) (
   input  wire logic              clock,
   input  wire logic              rd_en,
   input  wire logic [AW-1:0]     rd_addr,
   output logic [WORD_W-1:0]      rd_data,
   input  wire logic              wr_en,
   input  wire logic [AW-1:0]     wr_addr,
   input  wire logic [WORD_W-1:0] wr_data
);

   logic [WORD_W-1:0] mem [DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> design/tmb_median.sv
// ----------------------------------------------------------------------------
// tmb_median
// Rank selection per channel: for each valid slot count the smaller and equal
// valid samples, and pick the sample whose rank range covers the middle index.
// ----------------------------------------------------------------------------
`default_nettype none

module tmb_median
   import tmb_pkg::*;
#(
   parameter int unsigned WINDOW = WINDOW_DEFAULT,
   parameter int unsigned CW     = 4,
   parameter int unsigned WORD_W = 192
) (
   input  wire logic                         clock,
   input  wire logic                         load,
   input  wire logic [WORD_W-1:0]            word,
   input  wire logic [WINDOW-1:0]            valid_mask,
   input  wire logic [CW-1:0]                mid,
   output logic [CHANNELS*SAMPLE_W-1:0]      background
);

   logic [CHANNELS*SAMPLE_W-1:0] bg_ff, bg_in;

   always_comb begin : rank_select
      logic [WINDOW-1:0] lt_vec;
      logic [WINDOW-1:0] eq_vec;
      logic [CW:0]       lt_cnt;
      logic [CW:0]       eq_cnt;
      sample_type        xi;
      sample_type        xj;
      sample_type        pick;
      bg_in = '0;
      for (int ch = 0; ch < CHANNELS; ch++) begin
         pick = '0;
         for (int i = 0; i < WINDOW; i++) begin
            xi = word[(i*CHANNELS + ch)*SAMPLE_W +: SAMPLE_W];
            for (int j = 0; j < WINDOW; j++) begin
               xj        = word[(j*CHANNELS + ch)*SAMPLE_W +: SAMPLE_W];
               lt_vec[j] = valid_mask[j] && (xj < xi);
               eq_vec[j] = valid_mask[j] && (xj == xi);
            end
            lt_cnt = (CW + 1)'($countones(lt_vec));
            eq_cnt = (CW + 1)'($countones(eq_vec));
            // equal samples share a value, so OR-ing every hit is safe
            if (valid_mask[i] && (lt_cnt <= {1'b0, mid}) && ({1'b0, mid} < lt_cnt + eq_cnt)) begin
               pick = pick | xi;
            end
         end
         bg_in[ch*SAMPLE_W +: SAMPLE_W] = pick;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         bg_ff <= bg_in;
      end
   end

   assign background = bg_ff;

endmodule

`default_nettype wire
